// File: rtl/transfer_entropy_histogram_unit_assert.svh
// Assertion macros for the transfer entropy histogram unit.
// Depends on nothing; included by the top level.
`ifndef TRANSFER_ENTROPY_HISTOGRAM_UNIT_ASSERT_SVH
`define TRANSFER_ENTROPY_HISTOGRAM_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TEH_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TEH_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: rtl/teh_pkg.sv
// Package of the transfer entropy histogram unit: constants, state type, log request type.
// Depends on nothing.
package teh_pkg;
  localparam int MAX_LEVELS_DEF = 16;
  localparam int MAX_PAIRS_DEF  = 1048576;
  localparam int FRAC_BITS_DEF  = 20;
  localparam int SYM_W   = 4;
  localparam int CNT_W   = 21;
  localparam int OUT_W   = 24;
  localparam int LEV_W   = 5;
  localparam int OUT_FRAC = 20;

  typedef enum logic [5:0] {
    ST_RUN   = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_SWEEP = 6'b000100,
    ST_LOG   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // Handshake between the sweep controller and the log unit.
  typedef struct packed {
    logic        start;
    logic [31:0] x;
  } log_req_t;
endpackage

// File: rtl/teh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module teh_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/teh_log2.sv
// Iterative fixed-point log2 of a count, one fraction bit per cycle.
// Depends on teh_pkg.
module teh_log2 import teh_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  log_req_t              req,
  output logic                  done,
  output logic [FRAC_BITS+5:0]  result
);
  logic [31:0] m;
  logic [4:0] e;
  logic [FRAC_BITS-1:0] frac;
  logic [$clog2(FRAC_BITS+2)-1:0] cnt;
  logic busy;
  logic [63:0] sq;
  logic [4:0] e_next;
  logic [31:0] m_next;
  logic zero;

  always_comb begin
    e_next = '0;
    for (int i = 0; i < 32; i++) begin
      if (req.x[i]) e_next = 5'(i);
    end
    m_next = req.x << (5'd31 - e_next);
    sq = 64'(m) * 64'(m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (cnt == ($clog2(FRAC_BITS+2))'(FRAC_BITS));
      if (req.start) begin
        busy <= 1'b1;
        e <= e_next;
        m <= m_next;
        zero <= (req.x == '0);
        frac <= '0;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == ($clog2(FRAC_BITS+2))'(FRAC_BITS)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
          frac <= {frac[FRAC_BITS-2:0], sq[63]};
          m <= sq[63] ? sq[63:32] : sq[62:31];
        end
      end
    end
  end

  assign result = zero ? '0 : {1'b0, e, frac};
endmodule

// File: rtl/teh_divider.sv
// Restoring divider, one quotient bit per cycle, 64 by 21 bits.
// Depends on teh_pkg.
module teh_divider import teh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] rem;
  logic [6:0] cnt;
  logic busy;
  logic [64:0] trial;

  assign trial = {rem[63:0], quotient[63]} - 65'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == 7'd63);
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        quotient <= dividend;
        cnt <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quotient[63]};
          quotient <= {quotient[62:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

// File: rtl/transfer_entropy_histogram_unit.sv
// Top level of the transfer entropy histogram unit.
// Depends on teh_pkg, teh_ram, teh_log2, teh_divider and the assertion header.
//
// A counted symbol pair takes a read phase, which reads the four histogram
// memories, and a write phase, which writes the incremented counts back, so
// the registered memory read sets the rate. After reset the four stores are
// cleared by a pass over all 65536 joint addresses, one entry of each a
// cycle, during which no beat is accepted; the same pass follows every result.
// On the last pair the sweep walks all 65536 joint bins unless no pair was
// counted; a nonzero bin runs the shared log unit four times. A divide follows
// if pos exceeds neg, then the result beat, which waits on m_axis_tready.
`include "transfer_entropy_histogram_unit_assert.svh"
module transfer_entropy_histogram_unit import teh_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF,
  parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // source_symbol [3:0], target_symbol [7:4]
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // entropy_bits [23:0], pairs_counted [44:24], overflow [45], zero [47:46]
  output logic [47:0] m_axis_tdata
);
  localparam int LW = $clog2(MAX_LEVELS);
  localparam int A1 = LW;
  localparam int A2 = 2 * LW;
  localparam int A3 = 3 * LW;
  localparam int A4 = 4 * LW;
  localparam int LG = FRAC_BITS + 6;

  state_t state;
  logic [LEV_W-1:0] levels_reg;
  logic [LEV_W-1:0] lev;
  logic [LW-1:0] s_fit, t_fit, sp, tp, tp2;
  logic [CNT_W-1:0] pairs;
  logic [1:0] hist;
  logic ovf;
  logic [A4-1:0] clr_addr;
  logic [A4:0] sw_idx;

  logic wr_phase;
  logic [LW-1:0] w_s;
  logic [LW-1:0] w_t_q;
  logic last_q;
  logic [CNT_W-1:0] r_past, r_np, r_cond, r_joint;
  logic [A1-1:0] ra_past;
  logic [A2-1:0] ra_np;
  logic [A3-1:0] ra_cond;
  logic [A4-1:0] ra_joint;
  logic [A1-1:0] wa_past;
  logic [A2-1:0] wa_np;
  logic [A3-1:0] wa_cond;
  logic [A4-1:0] wa_joint;
  logic we;
  logic [CNT_W-1:0] wd_past, wd_np, wd_cond, wd_joint;

  logic [1:0] sw_step;
  logic [2:0] lg_sel;
  logic sw_wait;
  logic [63:0] pos, neg;
  logic [LG:0] acc, lsum;
  logic [CNT_W+LG:0] prod;
  logic [CNT_W-1:0] c_hold;
  log_req_t lreq;
  logic lg_start;
  logic [31:0] lg_x;
  logic lg_done;
  logic [LG-1:0] lg_res;
  logic div_start, div_done;
  logic [63:0] quot;
  logic [OUT_W-1:0] ent;
  logic accept;
  logic counting;
  logic sweep_end, sweep_hit, log_more;

  always_comb begin
    lev = levels_reg;
    if (levels_reg < 5'd2) lev = 5'd2;
    if (levels_reg > LEV_W'(MAX_LEVELS)) lev = LEV_W'(MAX_LEVELS);
    s_fit = ({1'b0, s_axis_tdata[3:0]} >= lev) ? LW'(lev - 1'b1)
                                               : LW'(s_axis_tdata[3:0]);
    t_fit = ({1'b0, s_axis_tdata[7:4]} >= lev) ? LW'(lev - 1'b1)
                                               : LW'(s_axis_tdata[7:4]);
  end

  assign s_axis_tready = (state == ST_RUN) && !wr_phase;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign counting = (hist == 2'd2) && ((pairs - CNT_W'(2)) < CNT_W'(MAX_PAIRS));

  assign sweep_end = (state == ST_SWEEP) && (pairs <= CNT_W'(2) || sw_idx[A4]);
  assign sweep_hit = (state == ST_SWEEP) && !sweep_end && sw_step[0] && (r_joint != '0);
  assign log_more = (state == ST_LOG) && sw_wait && lg_done && (lg_sel != 3'd3);

  always_comb begin
    ra_past = sp;
    ra_np = {s_fit, sp};
    ra_cond = {sp, tp, tp2};
    ra_joint = {s_fit, sp, tp, tp2};
    if (state == ST_SWEEP || state == ST_LOG) begin
      ra_joint = sw_idx[A4-1:0];
      ra_past = sw_idx[A3-1:A2];
      ra_cond = sw_idx[A3-1:0];
      ra_np = {sw_idx[A4-1:A3], sw_idx[A3-1:A2]};
    end
    we = 1'b0;
    wa_past = '0;
    wa_np = '0; wa_cond = '0; wa_joint = '0;
    wd_past = '0; wd_np = '0; wd_cond = '0; wd_joint = '0;
    if (state == ST_CLEAR) begin
      we = 1'b1;
      wa_joint = clr_addr;
      wa_cond = clr_addr[A3-1:0];
      wa_np = clr_addr[A2-1:0];
      wa_past = clr_addr[A1-1:0];
    end else if (wr_phase) begin
      we = 1'b1;
      wa_past = sp;
      wa_np = {w_s, sp};
      wa_cond = {sp, tp, tp2};
      wa_joint = {w_s, sp, tp, tp2};
      wd_past = r_past + 1'b1;
      wd_np = r_np + 1'b1;
      wd_cond = r_cond + 1'b1;
      wd_joint = r_joint + 1'b1;
    end
  end

  teh_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEVELS)) u_past (
    .clk, .we, .waddr(wa_past), .wdata(wd_past), .raddr(ra_past), .rdata(r_past));
  teh_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEVELS**2)) u_np (
    .clk, .we, .waddr(wa_np), .wdata(wd_np), .raddr(ra_np), .rdata(r_np));
  teh_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEVELS**3)) u_cond (
    .clk, .we, .waddr(wa_cond), .wdata(wd_cond), .raddr(ra_cond), .rdata(r_cond));
  teh_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEVELS**4)) u_joint (
    .clk, .we, .waddr(wa_joint), .wdata(wd_joint), .raddr(ra_joint),
    .rdata(r_joint));

  always_comb begin
    case (lg_sel)
      3'd0:    lg_x = 32'(c_hold);
      3'd1:    lg_x = 32'(r_past);
      3'd2:    lg_x = 32'(r_cond);
      default: lg_x = 32'(r_np);
    endcase
  end

  assign lreq = {lg_start, lg_x};

  teh_log2 #(.FRAC_BITS(FRAC_BITS)) u_log (
    .clk, .rst, .req(lreq), .done(lg_done), .result(lg_res));

  teh_divider u_div (
    .clk, .rst, .start(div_start), .dividend(pos - neg), .divisor(pairs - 2'd2),
    .done(div_done), .quotient(quot));

  always_comb begin
    lsum = acc + (LG+1)'(lg_res);
    prod = (CNT_W+LG+1)'(c_hold) * (CNT_W+LG+1)'(lsum);
  end

  always_comb begin
    ent = OUT_W'(quot >> (FRAC_BITS - OUT_FRAC));
    if (FRAC_BITS >= OUT_FRAC) begin
      if ((quot >> (FRAC_BITS - OUT_FRAC)) > 64'(2**OUT_W - 1)) ent = '1;
    end else begin
      if (quot > (64'(2**OUT_W - 1) >> (OUT_FRAC - FRAC_BITS))) ent = '1;
      else ent = OUT_W'(quot << (OUT_FRAC - FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_phase <= 1'b0;
      lg_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      wr_phase <= accept && counting;
      lg_start <= sweep_hit || log_more;
      div_start <= sweep_end && (pairs > CNT_W'(2)) && (pos > neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      levels_reg <= 5'd16;
      clr_addr <= '0;
      hist <= '0; pairs <= '0; ovf <= 1'b0;
      sp <= '0; tp <= '0; tp2 <= '0;
      m_axis_tvalid <= 1'b0;
      sw_wait <= 1'b0;
    end else begin
      if (cfg_we) levels_reg <= cfg_wdata;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= ST_RUN;
        end
        ST_RUN: begin
          if (wr_phase) begin
            tp2 <= tp; tp <= w_t_q; sp <= w_s;
            pairs <= pairs + 1'b1;
            if (last_q) begin
              state <= ST_SWEEP; sw_idx <= '0; pos <= '0; neg <= '0; sw_step <= '0;
            end
          end else if (accept) begin
            last_q <= s_axis_tlast;
            w_s <= s_fit; w_t_q <= t_fit;
            if (!counting) begin
              if (hist != 2'd2) begin
                hist <= hist + 1'b1;
                tp2 <= tp; tp <= t_fit; sp <= s_fit;
                pairs <= pairs + 1'b1;
              end else begin
                ovf <= 1'b1;
              end
              if (s_axis_tlast) begin
                state <= ST_SWEEP; sw_idx <= '0; pos <= '0; neg <= '0; sw_step <= '0;
              end
            end
          end
        end
        ST_SWEEP: begin
          if (sweep_end) begin
            state <= ST_DIV;
            sw_wait <= 1'b0;
          end else if (!sw_step[0]) begin
            sw_step <= 2'd1;
          end else begin
            sw_step <= 2'd0;
            if (r_joint != '0) begin
              c_hold <= r_joint; lg_sel <= 3'd0; acc <= '0;
              sw_wait <= 1'b1;
              state <= ST_LOG;
            end else begin
              sw_idx <= sw_idx + 1'b1;
            end
          end
        end
        ST_LOG: begin
          if (sw_wait && lg_done) begin
            if (lg_sel == 3'd1) begin
              pos <= pos + 64'(prod);
              acc <= '0;
            end else begin
              acc <= lsum;
            end
            if (lg_sel == 3'd3) begin
              neg <= neg + 64'(prod);
              sw_idx <= sw_idx + 1'b1;
              sw_wait <= 1'b0;
              state <= ST_SWEEP;
            end else begin
              lg_sel <= lg_sel + 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (!(pairs > CNT_W'(2) && pos > neg)) begin
            m_axis_tdata <= {2'b00, ovf,
                             (pairs > CNT_W'(2)) ? CNT_W'(pairs - 2'd2) : CNT_W'(0),
                             OUT_W'(0)};
            m_axis_tvalid <= 1'b1; state <= ST_OUT;
          end else if (div_done) begin
            m_axis_tdata <= {2'b00, ovf, CNT_W'(pairs - 2'd2), ent};
            m_axis_tvalid <= 1'b1; state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= ST_CLEAR; clr_addr <= '0;
            hist <= '0; pairs <= '0; ovf <= 1'b0;
            sp <= '0; tp <= '0; tp2 <= '0;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  `TEH_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_RUN, !s_axis_tready)
  `TEH_ASSERT_NEXT(a_write_follows, clk, rst, accept && counting, wr_phase)
  `TEH_ASSERT_IMP(a_out_state, clk, rst, m_axis_tvalid, state == ST_OUT)
endmodule
